[rtl/qssr_pkg.sv]
// ----------------------------------------------------------------------------
// qssr_pkg
// Shared types and constants for the four-channel servo slew ramp.
// ----------------------------------------------------------------------------
package qssr_pkg;

   localparam int CHANNELS   = 4;
   localparam int DUTY_BITS  = 10;
   localparam int CHANNEL_W  = 2;
   localparam int VALUE_W    = 16;
   localparam int KIND_W     = 3;
   localparam int REQ_DATA_W = ((CHANNEL_W + VALUE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((CHANNELS * DUTY_BITS + 7) / 8) * 8;
   localparam int SUM_W      = DUTY_BITS + 2;

   localparam logic [VALUE_W-1:0] DUTY_MAX = VALUE_W'((1 << DUTY_BITS) - 1);
   localparam logic [1:0]         DIR_STOP = 2'd2;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK      = 3'd0,
      KIND_SET_LOWER = 3'd1,
      KIND_SET_UPPER = 3'd2,
      KIND_SET_DIR   = 3'd3,
      KIND_SET_DIV   = 3'd4
   } kind_type;

   typedef logic [DUTY_BITS-1:0] duty_type;

   // decoded command shared by all channel units
   typedef struct packed {
      logic               tick;
      logic               set_lower;
      logic               set_upper;
      logic               set_dir;
      logic               set_div;
      logic [VALUE_W-1:0] value;
   } cmd_type;

endpackage

[rtl/quad_servo_slew_ramp.sv]
// ----------------------------------------------------------------------------
// quad_servo_slew_ramp
// Four-channel servo slew ramp: command and tick transactions in, the duty
// of every channel out, one result per transaction.
// ----------------------------------------------------------------------------
// Each request is held in the input register until it can be applied to the
// channel units, and its result is held in the result register until taken.
// Throughput: 1 transaction per cycle while rsp_tready does not hold the
// result register; the channel units update in a single pass.
// Reset: synchronous; all channel state returns to its initial values
// (direction stopped, all else zero) in the reset cycle, valid flags cleared.
// ----------------------------------------------------------------------------
module quad_servo_slew_ramp
   import qssr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // channel[1:0], value[17:2]
   input  logic [KIND_W-1:0]     req_tuser,  // kind[2:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // duty_ch0, duty_ch1, ... 10 bits each
);

   logic                 in_valid_ff, in_valid_in;
   logic [KIND_W-1:0]    kind_ff;
   logic [CHANNEL_W-1:0] channel_ff;
   logic [VALUE_W-1:0]   value_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic     advance;
   cmd_type  cmd;
   duty_type duty_now  [CHANNELS];
   duty_type duty_next [CHANNELS];

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      cmd           = '0;
      cmd.value     = value_ff;
      unique case (kind_ff)
         KIND_TICK:      cmd.tick      = 1'b1;
         KIND_SET_LOWER: cmd.set_lower = 1'b1;
         KIND_SET_UPPER: cmd.set_upper = 1'b1;
         KIND_SET_DIR:   cmd.set_dir   = 1'b1;
         KIND_SET_DIV:   cmd.set_div   = 1'b1;
         default:        cmd.value     = value_ff;
      endcase
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      qssr_channel u_channel (
         .clock     (clock),
         .reset     (reset),
         .update    (advance),
         .selected  (32'(channel_ff) == c),
         .cmd       (cmd),
         .duty_now  (duty_now[c]),
         .duty_next (duty_next[c])
      );
   end

   always_comb begin
      out_data_in = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         out_data_in[c*DUTY_BITS +: DUTY_BITS] = duty_next[c];
      end
      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold the payload until the transaction moves on
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         kind_ff    <= req_tuser;
         channel_ff <= req_tdata[CHANNEL_W-1:0];
         value_ff   <= req_tdata[CHANNEL_W +: VALUE_W];
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

`ifndef SYNTHESIS
   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("applied transaction did not produce a result");

   a_blocked_not_ready: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_tready)
      else $error("request accepted while input register is blocked");

   a_set_keeps_duty: assert property (@(posedge clock) disable iff (reset)
      (advance && !cmd.tick) |-> (duty_next[0] == duty_now[0]
                                  && duty_next[CHANNELS-1] == duty_now[CHANNELS-1]))
      else $error("set command changed an output duty");

   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_tdata[DUTY_BITS-1:0] == duty_now[0]))
      else $error("result does not match channel duty");
`endif

endmodule

[rtl/qssr_channel.sv]
// ----------------------------------------------------------------------------
// qssr_channel
// State and single-pass update of one servo channel: limits, direction,
// prescaler, position and output duty.
// ----------------------------------------------------------------------------
module qssr_channel
   import qssr_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     update,     // a transaction is applied this cycle
   input  logic     selected,   // this channel is addressed by a set command
   input  cmd_type  cmd,
   output duty_type duty_now,
   output duty_type duty_next
);

   duty_type           lower_ff, lower_in;
   duty_type           upper_ff, upper_in;
   logic [1:0]         dir_ff, dir_in;
   logic [VALUE_W-1:0] div_ff, div_in;
   logic [VALUE_W-1:0] count_ff, count_in;
   duty_type           pos_ff, pos_in;
   duty_type           duty_ff, duty_in;

   logic [VALUE_W-1:0] count_inc;
   logic [SUM_W-1:0]   step_sum;
   duty_type           step_pos;
   duty_type           sat_value;

   always_comb begin
      count_inc = count_ff + VALUE_W'(1);
      step_sum  = {2'b00, pos_ff} + SUM_W'(dir_ff) - SUM_W'(DIR_STOP);
      // lower clamp takes priority over upper when the limits cross
      if ($signed(step_sum) < $signed({2'b00, lower_ff})) begin
         step_pos = lower_ff;
      end else if ($signed(step_sum) > $signed({2'b00, upper_ff})) begin
         step_pos = upper_ff;
      end else begin
         step_pos = step_sum[DUTY_BITS-1:0];
      end
      sat_value = (cmd.value > DUTY_MAX) ? DUTY_MAX[DUTY_BITS-1:0]
                                         : cmd.value[DUTY_BITS-1:0];
   end

   always_comb begin
      lower_in = lower_ff;
      upper_in = upper_ff;
      dir_in   = dir_ff;
      div_in   = div_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      duty_in  = duty_ff;
      if (update && cmd.tick) begin
         if (count_inc < div_ff) begin
            count_in = count_inc;
         end else begin
            count_in = '0;
            if (dir_ff == DIR_STOP) begin
               duty_in = '0;
            end else begin
               pos_in  = step_pos;
               duty_in = step_pos;
            end
         end
      end else if (update && selected) begin
         if (cmd.set_lower) begin
            lower_in = sat_value;
            if (pos_ff < sat_value) begin
               pos_in = sat_value;
            end
         end
         if (cmd.set_upper) begin
            upper_in = sat_value;
            if (pos_ff > sat_value) begin
               pos_in = sat_value;
            end
         end
         if (cmd.set_dir) begin
            dir_in = cmd.value[1:0];
         end
         if (cmd.set_div) begin
            div_in = cmd.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= '0;
         dir_ff   <= DIR_STOP;
         div_ff   <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
         duty_ff  <= '0;
      end else begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
         dir_ff   <= dir_in;
         div_ff   <= div_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         duty_ff  <= duty_in;
      end
   end

   assign duty_now  = duty_ff;
   assign duty_next = duty_in;

endmodule
